[sv/heart_rate_alarm_reporter_core_macros.svh]
// Assertion macros used by the heart-rate alarm reporter datapath.
`ifndef HEART_RATE_ALARM_REPORTER_CORE_MACROS_SVH
`define HEART_RATE_ALARM_REPORTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked at every rising clock edge outside reset.
`define HRAR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrar: same-cycle check failed");
// Next-cycle implication checked at every rising clock edge outside reset.
`define HRAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrar: next-cycle check failed");
`else
`define HRAR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HRAR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/hrar_pkg.sv]
// Types, constants and codes shared by the heart-rate alarm reporter modules.
`default_nettype none
package hrar_pkg;

   // Ring depth and derived widths.
   localparam int NUM_SAMPLES = 20;
   localparam int BPM_W       = 8;
   localparam int TIME_W      = 32;
   localparam int INTERVAL_W  = 22;
   localparam int POS_W       = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
   localparam int CNT_W       = $clog2(NUM_SAMPLES + 1);
   localparam int SUM_W       = $clog2(NUM_SAMPLES * 255 + 1);
   localparam int DIVC_W      = (SUM_W > 1) ? $clog2(SUM_W) : 1;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = INTERVAL_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NORMAL_INTERVAL   = 3'd0,
      CSR_CRITICAL_INTERVAL = 3'd1,
      CSR_STALE_TIMEOUT     = 3'd2,
      CSR_HIGH_LIMIT        = 3'd3,
      CSR_LOW_LIMIT         = 3'd4,
      CSR_CHANGE_STEP       = 3'd5
   } hrar_csr_index_type;

   // Register reset values.
   localparam logic [INTERVAL_W-1:0] NORMAL_INTERVAL_RST   = 22'd300000;
   localparam logic [INTERVAL_W-1:0] CRITICAL_INTERVAL_RST = 22'd30000;
   localparam logic [INTERVAL_W-1:0] STALE_TIMEOUT_RST     = 22'd10000;
   localparam logic [BPM_W-1:0]      HIGH_LIMIT_RST        = 8'd130;
   localparam logic [BPM_W-1:0]      LOW_LIMIT_RST         = 8'd45;
   localparam logic [BPM_W-1:0]      CHANGE_STEP_RST       = 8'd10;

   // Item kinds.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [BPM_W-1:0]  sample_bpm;
      logic [TIME_W-1:0] now_ms;
   } hrar_req_type;

   typedef struct packed {
      logic [BPM_W-1:0] mean_bpm;
      logic             critical_alert;
   } hrar_rsp_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] normal_interval_ms;
      logic [INTERVAL_W-1:0] critical_interval_ms;
      logic [INTERVAL_W-1:0] stale_timeout_ms;
      logic [BPM_W-1:0]      high_limit_bpm;
      logic [BPM_W-1:0]      low_limit_bpm;
      logic [BPM_W-1:0]      change_step_bpm;
   } hrar_cfg_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic sample_write;
      logic tick_load;
      logic clear_buf;
      logic sum_clear;
      logic sum_read;
      logic div_init;
      logic div_step;
      logic commit;
   } hrar_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic count_zero;
      logic stale;
      logic sum_last;
      logic div_last;
      logic report;
      logic rsp_full;
   } hrar_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SUM,
      ST_DRAIN,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_DECIDE
   } hrar_state_type;

endpackage
`default_nettype wire

[sv/heart_rate_alarm_reporter_core.sv]
// A sample item is stored from the idle state; the next item is accepted in the following cycle.
// An evaluate tick that finds the buffer empty or stale returns to idle after the stale check.
// Otherwise it passes through the accepting idle state, a stale check, one ring read per stored
// sample, a drain and a divider load, 13 divide steps and a decision.
// A due report waits while an earlier report has not yet been taken from the output register.
// Synchronous active-high reset restores register defaults and empties the buffer, not the ring.
`default_nettype none
module heart_rate_alarm_reporter_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  hrar_pkg::hrar_req_type               req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output hrar_pkg::hrar_rsp_type               rsp_payload,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [hrar_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hrar_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hrar_pkg::*;

   hrar_cfg_type    cfg;
   hrar_cmd_type    cmd;
   hrar_status_type status;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   hrar_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_o     (cfg)
   );

   hrar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.req_type),
      .req_ready (req_ready),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   hrar_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_i     (req_payload),
      .cfg_i     (cfg),
      .cmd_i     (cmd),
      .status_o  (status),
      .rsp_o     (rsp_payload),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

endmodule
`default_nettype wire

[sv/hrar_csr.sv]
// Configuration registers of the heart-rate alarm reporter.
`default_nettype none
module hrar_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   input  wire logic [hrar_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hrar_pkg::CSR_DATA_W-1:0] csr_wdata,
   output hrar_pkg::hrar_cfg_type              cfg_o
);
   import hrar_pkg::*;

   hrar_cfg_type cfg_ff;
   hrar_cfg_type cfg_in;

   // Decode the register index; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NORMAL_INTERVAL:   cfg_in.normal_interval_ms   = csr_wdata;
            CSR_CRITICAL_INTERVAL: cfg_in.critical_interval_ms = csr_wdata;
            CSR_STALE_TIMEOUT:     cfg_in.stale_timeout_ms     = csr_wdata;
            CSR_HIGH_LIMIT:        cfg_in.high_limit_bpm       = csr_wdata[BPM_W-1:0];
            CSR_LOW_LIMIT:         cfg_in.low_limit_bpm        = csr_wdata[BPM_W-1:0];
            CSR_CHANGE_STEP:       cfg_in.change_step_bpm      = csr_wdata[BPM_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_interval_ms   <= NORMAL_INTERVAL_RST;
         cfg_ff.critical_interval_ms <= CRITICAL_INTERVAL_RST;
         cfg_ff.stale_timeout_ms     <= STALE_TIMEOUT_RST;
         cfg_ff.high_limit_bpm       <= HIGH_LIMIT_RST;
         cfg_ff.low_limit_bpm        <= LOW_LIMIT_RST;
         cfg_ff.change_step_bpm      <= CHANGE_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_o = cfg_ff;

endmodule
`default_nettype wire

[sv/hrar_ctrl.sv]
// Controller state machine that sequences sample storage and tick evaluation.
`default_nettype none
module hrar_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_kind,
   output logic                           req_ready,
   input  hrar_pkg::hrar_status_type      status_i,
   output hrar_pkg::hrar_cmd_type         cmd_o
);
   import hrar_pkg::*;

   hrar_state_type state_ff;
   hrar_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd_o     = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == REQ_SAMPLE) begin
                  cmd_o.sample_write = 1'b1;
               end else begin
                  cmd_o.tick_load = 1'b1;
                  state_in        = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // Empty buffer does nothing; stale data clears the buffer.
            if (status_i.count_zero) begin
               state_in = ST_IDLE;
            end else if (status_i.stale) begin
               cmd_o.clear_buf = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd_o.sum_clear = 1'b1;
               state_in        = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd_o.sum_read = 1'b1;
            if (status_i.sum_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd_o.div_init = 1'b1;
            state_in       = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd_o.div_step = 1'b1;
            if (status_i.div_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // Hold a due report while an earlier one still sits in the output register.
            if (!status_i.report) begin
               state_in = ST_IDLE;
            end else if (!status_i.rsp_full) begin
               cmd_o.commit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[sv/hrar_dp.sv]
// Datapath: sample ring, serial sum, restoring divider, report decision and output register.
`default_nettype none
`include "heart_rate_alarm_reporter_core_macros.svh"
module hrar_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  hrar_pkg::hrar_req_type     req_i,
   input  hrar_pkg::hrar_cfg_type     cfg_i,
   input  hrar_pkg::hrar_cmd_type     cmd_i,
   output hrar_pkg::hrar_status_type  status_o,
   output hrar_pkg::hrar_rsp_type     rsp_o,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready
);
   import hrar_pkg::*;

   // Sample ring memory and its registered read port.
   logic [BPM_W-1:0]  ring_ff [NUM_SAMPLES];
   logic [BPM_W-1:0]  rd_data_ff;

   // Buffer control.
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] last_sample_ff, last_sample_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // Serial sum.
   logic [POS_W-1:0]  idx_ff, idx_in;
   logic              rd_pend_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   // Restoring divider.
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [DIVC_W-1:0] div_cnt_ff, div_cnt_in;
   logic [CNT_W:0]    div_trial;
   logic [CNT_W:0]    div_divisor;
   logic              div_bit;

   // Report history.
   logic [TIME_W-1:0] last_rpt_time_ff, last_rpt_time_in;
   logic [BPM_W-1:0]  last_rpt_mean_ff, last_rpt_mean_in;
   logic              last_rpt_crit_ff, last_rpt_crit_in;
   logic              never_ff, never_in;

   // Output register.
   hrar_rsp_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Decision terms.
   logic [BPM_W-1:0]      mean;
   logic                  crit;
   logic [INTERVAL_W-1:0] interval;
   logic [TIME_W-1:0]     rpt_age;
   logic [TIME_W-1:0]     sample_age;
   logic [BPM_W-1:0]      diff;
   logic                  due;
   logic                  moved;
   logic                  flipped;

   // Ring write on a sample item, one read a cycle during the sum.
   always_ff @(posedge clock) begin
      if (cmd_i.sample_write) begin
         ring_ff[pos_ff] <= req_i.sample_bpm;
      end
      rd_data_ff <= ring_ff[idx_ff];
   end

   // Mean and report decision, valid once the divide has finished.
   always_comb begin
      mean       = quo_ff[BPM_W-1:0];
      crit       = (mean > cfg_i.high_limit_bpm) || (mean < cfg_i.low_limit_bpm);
      interval   = crit ? cfg_i.critical_interval_ms : cfg_i.normal_interval_ms;
      rpt_age    = now_ff - last_rpt_time_ff;
      sample_age = now_ff - last_sample_ff;
      due        = never_ff || (rpt_age > TIME_W'(interval));
      diff       = (mean > last_rpt_mean_ff) ? (mean - last_rpt_mean_ff)
                                             : (last_rpt_mean_ff - mean);
      moved      = (diff != '0) && (diff >= cfg_i.change_step_bpm);
      flipped    = crit != last_rpt_crit_ff;
   end

   // One quotient bit per step.
   always_comb begin
      div_divisor = {1'b0, count_ff};
      div_trial   = {rem_ff, quo_ff[SUM_W-1]};
      div_bit     = div_trial >= div_divisor;
   end

   // Status to the controller.
   always_comb begin
      status_o.count_zero = count_ff == '0;
      status_o.stale      = sample_age > TIME_W'(cfg_i.stale_timeout_ms);
      status_o.sum_last   = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
      status_o.div_last   = div_cnt_ff == DIVC_W'(SUM_W - 1);
      status_o.report     = due || moved || flipped;
      status_o.rsp_full   = rsp_valid_ff && !rsp_ready;
   end

   // Next values of all datapath registers.
   always_comb begin
      pos_in           = pos_ff;
      count_in         = count_ff;
      last_sample_in   = last_sample_ff;
      now_in           = now_ff;
      idx_in           = idx_ff;
      sum_in           = sum_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      div_cnt_in       = div_cnt_ff;
      last_rpt_time_in = last_rpt_time_ff;
      last_rpt_mean_in = last_rpt_mean_ff;
      last_rpt_crit_in = last_rpt_crit_ff;
      never_in         = never_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;

      // Store a sample: the position wraps, the count saturates.
      if (cmd_i.sample_write) begin
         pos_in         = (pos_ff == POS_W'(NUM_SAMPLES - 1)) ? '0 : pos_ff + POS_W'(1);
         count_in       = (count_ff == CNT_W'(NUM_SAMPLES)) ? count_ff
                                                            : count_ff + CNT_W'(1);
         last_sample_in = req_i.now_ms;
      end
      if (cmd_i.tick_load) begin
         now_in = req_i.now_ms;
      end
      if (cmd_i.clear_buf) begin
         pos_in   = '0;
         count_in = '0;
      end

      // Sum entries zero to count minus one; the read data lands in the cycle after the read.
      if (cmd_i.sum_clear) begin
         sum_in = '0;
         idx_in = '0;
      end
      if (cmd_i.sum_read && !status_o.sum_last) begin
         idx_in = idx_ff + POS_W'(1);
      end
      if (rd_pend_ff) begin
         sum_in = sum_ff + SUM_W'(rd_data_ff);
      end

      // Restoring division of the sum by the fill count.
      if (cmd_i.div_init) begin
         rem_in     = '0;
         quo_in     = sum_ff;
         div_cnt_in = '0;
      end
      if (cmd_i.div_step) begin
         rem_in     = div_bit ? CNT_W'(div_trial - div_divisor) : CNT_W'(div_trial);
         quo_in     = {quo_ff[SUM_W-2:0], div_bit};
         div_cnt_in = div_cnt_ff + DIVC_W'(1);
      end

      // Record the report and load the output register.
      if (cmd_i.commit) begin
         last_rpt_time_in      = now_ff;
         last_rpt_mean_in      = mean;
         last_rpt_crit_in      = crit;
         never_in              = 1'b0;
         rsp_in.mean_bpm       = mean;
         rsp_in.critical_alert = crit;
         rsp_valid_in          = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= '0;
         count_ff         <= '0;
         last_sample_ff   <= '0;
         rd_pend_ff       <= 1'b0;
         last_rpt_time_ff <= '0;
         last_rpt_mean_ff <= '0;
         last_rpt_crit_ff <= 1'b0;
         never_ff         <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pos_ff           <= pos_in;
         count_ff         <= count_in;
         last_sample_ff   <= last_sample_in;
         rd_pend_ff       <= cmd_i.sum_read;
         last_rpt_time_ff <= last_rpt_time_in;
         last_rpt_mean_ff <= last_rpt_mean_in;
         last_rpt_crit_ff <= last_rpt_crit_in;
         never_ff         <= never_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      idx_ff     <= idx_in;
      sum_ff     <= sum_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      div_cnt_ff <= div_cnt_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_o     = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // The fill count never passes the ring depth.
   `HRAR_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(NUM_SAMPLES))
   // Reads during the sum stay inside the filled part of the ring.
   `HRAR_ASSERT_IMPLY(a_read_in_fill, clock, reset, cmd_i.sum_read, CNT_W'(idx_ff) < count_ff)
   // The divider only runs with a nonzero divisor.
   `HRAR_ASSERT_IMPLY(a_div_nonzero, clock, reset, cmd_i.div_step, count_ff != '0)
   // A new report never overwrites one that has not been taken.
   `HRAR_ASSERT_IMPLY(a_commit_free, clock, reset, cmd_i.commit, !rsp_valid_ff || rsp_ready)
   // A committed report is offered in the next cycle.
   `HRAR_ASSERT_NEXT(a_commit_shows, clock, reset, cmd_i.commit, rsp_valid_ff)

endmodule
`default_nettype wire

[bench/heart_rate_alarm_reporter_core_tb.sv]
// Self-checking testbench for the heart-rate alarm reporter core.
`timescale 1ns / 100ps
module heart_rate_alarm_reporter_core_tb;
   import hrar_pkg::*;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int SETTLE_CYCLES   = 64;
   localparam int PHASE_COUNT     = 7;
   localparam int ITEMS_PER_PHASE = 215;
   localparam int STEADY_PHASE    = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hrar_req_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hrar_rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Disables random idling on both sides for a long stretch.
   logic steady = 1'b0;
   int cycles = 0;
   int items_sent = 0;
   int ticks_sent = 0;
   logic [TIME_W-1:0] clock_ms;

   // Tracks the block's state and the reports it still owes.
   class report_tracker;
      hrar_cfg_type cfg;
      logic [BPM_W-1:0] ring [NUM_SAMPLES];
      int wr_pos;
      int fill;
      logic [TIME_W-1:0] sample_time;
      logic [TIME_W-1:0] report_time;
      logic [BPM_W-1:0] report_mean;
      logic report_crit;
      logic never_reported;
      hrar_rsp_type pending_reports [$];
      int mismatches;
      int reports_seen;
      int stale_clears;

      function new();
         cfg.normal_interval_ms   = NORMAL_INTERVAL_RST;
         cfg.critical_interval_ms = CRITICAL_INTERVAL_RST;
         cfg.stale_timeout_ms     = STALE_TIMEOUT_RST;
         cfg.high_limit_bpm       = HIGH_LIMIT_RST;
         cfg.low_limit_bpm        = LOW_LIMIT_RST;
         cfg.change_step_bpm      = CHANGE_STEP_RST;
         wr_pos = 0;
         fill = 0;
         sample_time = '0;
         report_time = '0;
         report_mean = '0;
         report_crit = 1'b0;
         never_reported = 1'b1;
         mismatches = 0;
         reports_seen = 0;
         stale_clears = 0;
      endfunction

      // Register writes; byte-wide registers keep only their low bits.
      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_NORMAL_INTERVAL: begin
               cfg.normal_interval_ms = data;
            end
            CSR_CRITICAL_INTERVAL: begin
               cfg.critical_interval_ms = data;
            end
            CSR_STALE_TIMEOUT: begin
               cfg.stale_timeout_ms = data;
            end
            CSR_HIGH_LIMIT: begin
               cfg.high_limit_bpm = data[BPM_W-1:0];
            end
            CSR_LOW_LIMIT: begin
               cfg.low_limit_bpm = data[BPM_W-1:0];
            end
            CSR_CHANGE_STEP: begin
               cfg.change_step_bpm = data[BPM_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Applies one accepted item and queues the report it causes, if any.
      function void note_item(hrar_req_type item);
         logic [TIME_W-1:0] age;
         logic [TIME_W-1:0] since;
         logic [INTERVAL_W-1:0] interval;
         logic [BPM_W-1:0] mean;
         logic [BPM_W-1:0] diff;
         logic crit;
         logic due;
         logic moved;
         logic flipped;
         int sum;
         hrar_rsp_type rpt;
         if (item.req_type == REQ_SAMPLE) begin
            ring[wr_pos] = item.sample_bpm;
            wr_pos = (wr_pos + 1) % NUM_SAMPLES;
            if (fill < NUM_SAMPLES) fill++;
            sample_time = item.now_ms;
            return;
         end
         if (fill == 0) return;
         // Old data empties the buffer before anything is evaluated.
         age = item.now_ms - sample_time;
         if (age > cfg.stale_timeout_ms) begin
            fill = 0;
            wr_pos = 0;
            stale_clears++;
            return;
         end
         sum = 0;
         for (int i = 0; i < fill; i++) sum += int'(ring[i]);
         mean = BPM_W'(sum / fill);
         crit = (mean > cfg.high_limit_bpm) || (mean < cfg.low_limit_bpm);
         interval = crit ? cfg.critical_interval_ms : cfg.normal_interval_ms;
         since = item.now_ms - report_time;
         due = never_reported || (since > interval);
         diff = (mean > report_mean) ? mean - report_mean : report_mean - mean;
         moved = (diff != 0) && (diff >= cfg.change_step_bpm);
         flipped = crit != report_crit;
         if (!(due || moved || flipped)) return;
         report_time = item.now_ms;
         report_mean = mean;
         report_crit = crit;
         never_reported = 1'b0;
         rpt.mean_bpm = mean;
         rpt.critical_alert = crit;
         pending_reports.push_back(rpt);
      endfunction

      // Compares one delivered report with the oldest one owed.
      function void check_report(hrar_rsp_type got);
         hrar_rsp_type want;
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected report: mean %0d alert %0b",
                        got.mean_bpm, got.critical_alert);
            return;
         end
         want = pending_reports.pop_front();
         reports_seen++;
         if (got.mean_bpm !== want.mean_bpm || got.critical_alert !== want.critical_alert) begin
            mismatches++;
            if (mismatches <= 10)
               $display("report mismatch: expected mean %0d alert %0b, got mean %0d alert %0b",
                        want.mean_bpm, want.critical_alert, got.mean_bpm, got.critical_alert);
         end
      endfunction
   endclass

   report_tracker tracker;

   heart_rate_alarm_reporter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_item),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: random back-pressure and checking of each accepted report.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_report(rsp_item);
      rsp_ready <= reset ? 1'b0 : (steady || $urandom_range(99) >= 19);
   end

   // Offers one item, with optional idle cycles first, and waits for its acceptance.
   task automatic send_item(input logic kind, input logic [BPM_W-1:0] bpm,
                            input logic [TIME_W-1:0] now);
      while (!steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= '{req_type: kind, sample_bpm: bpm, now_ms: now};
      do @(posedge clock); while (!req_ready);
      tracker.note_item('{req_type: kind, sample_bpm: bpm, now_ms: now});
      items_sent++;
      if (kind == REQ_TICK) ticks_sent++;
   endtask

   // Waits until every owed report has arrived and the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Holds one register write until the block takes it.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.set_reg(idx, data);
   endtask

   // Writes a full register setting; byte registers may carry junk in the upper bits.
   task automatic apply_setting(input hrar_cfg_type s, input logic noisy, input logic poke_spare);
      logic [CSR_DATA_W-BPM_W-1:0] upper;
      upper = noisy ? (CSR_DATA_W-BPM_W)'($urandom) : '0;
      write_reg(CSR_NORMAL_INTERVAL, s.normal_interval_ms);
      write_reg(CSR_CRITICAL_INTERVAL, s.critical_interval_ms);
      write_reg(CSR_STALE_TIMEOUT, s.stale_timeout_ms);
      write_reg(CSR_HIGH_LIMIT, {upper, s.high_limit_bpm});
      write_reg(CSR_LOW_LIMIT, {upper, s.low_limit_bpm});
      write_reg(CSR_CHANGE_STEP, {upper, s.change_step_bpm});
      if (poke_spare) begin
         write_reg(CSR_SPARE_A, '1);
         write_reg(CSR_SPARE_B, '1);
      end
      csr_valid <= 1'b0;
   endtask

   // Register setting for each random phase: defaults, extremes, crossing limits, random.
   function automatic hrar_cfg_type phase_setting(int p);
      hrar_cfg_type s;
      case (p)
         0: s = '{NORMAL_INTERVAL_RST, CRITICAL_INTERVAL_RST, STALE_TIMEOUT_RST,
                  HIGH_LIMIT_RST, LOW_LIMIT_RST, CHANGE_STEP_RST};
         1: s = '{22'd1, 22'd1, 22'd1, 8'd0, 8'd0, 8'd1};
         2: s = '{22'd3600000, 22'd3600000, 22'd3600000, 8'd255, 8'd255, 8'd255};
         3: s = '{22'd5000, 22'd2000, 22'd4000, 8'd100, 8'd200, 8'd0};
         5: begin
            s.normal_interval_ms   = INTERVAL_W'($urandom_range(1, 3600000));
            s.critical_interval_ms = INTERVAL_W'($urandom_range(1, 3600000));
            s.stale_timeout_ms     = INTERVAL_W'($urandom_range(1, 3600000));
            s.high_limit_bpm       = BPM_W'($urandom_range(0, 255));
            s.low_limit_bpm        = BPM_W'($urandom_range(0, 255));
            s.change_step_bpm      = BPM_W'($urandom_range(0, 255));
         end
         default: begin
            s.normal_interval_ms   = INTERVAL_W'($urandom_range(1, 20000));
            s.critical_interval_ms = INTERVAL_W'($urandom_range(1, 8000));
            s.stale_timeout_ms     = INTERVAL_W'($urandom_range(500, 20000));
            s.high_limit_bpm       = BPM_W'($urandom_range(90, 200));
            s.low_limit_bpm        = BPM_W'($urandom_range(20, 90));
            s.change_step_bpm      = BPM_W'($urandom_range(0, 30));
         end
      endcase
      return s;
   endfunction

   // One burst of samples around a base rate followed by evaluate ticks, sometimes preceded by
   // a fully random item; a tick is sometimes pushed past the stale timeout.
   task automatic run_session();
      int n;
      int base;
      int spread;
      int v;
      int step_max;
      int ticks;
      step_max = (tracker.cfg.stale_timeout_ms > 4000) ? 2000
               : int'(tracker.cfg.stale_timeout_ms) / 2 + 1;
      if ($urandom_range(99) < 10)
         send_item(logic'($urandom_range(0, 1)), BPM_W'($urandom), $urandom);
      n = ($urandom_range(99) < 10) ? $urandom_range(9, 25) : $urandom_range(1, 8);
      case ($urandom_range(0, 3))
         0: base = int'(tracker.cfg.high_limit_bpm);
         1: base = int'(tracker.cfg.low_limit_bpm);
         default: base = $urandom_range(0, 255);
      endcase
      spread = $urandom_range(0, 40);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 10) begin
            v = $urandom_range(0, 255);
         end else begin
            v = base + $urandom_range(0, 2 * spread) - spread;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
         clock_ms += $urandom_range(0, step_max);
         send_item(REQ_SAMPLE, BPM_W'(v), clock_ms);
      end
      ticks = $urandom_range(1, 3);
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(99) < 5)
            clock_ms += tracker.cfg.stale_timeout_ms + $urandom_range(1, 5000);
         else
            clock_ms += $urandom_range(0, step_max);
         send_item(REQ_TICK, BPM_W'($urandom), clock_ms);
      end
   endtask

   // Main sequence: reset, directed items, then random phases under several settings.
   initial begin
      hrar_cfg_type s;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed items under reset defaults: empty tick, first report, repeat without
      // change, critical flip, stale clear, time wrap, report due by interval.
      send_item(REQ_TICK, 8'h00, 32'd0);
      send_item(REQ_SAMPLE, 8'd0, 32'd0);
      send_item(REQ_SAMPLE, 8'd255, 32'd1);
      send_item(REQ_TICK, 8'hAA, 32'd2);
      send_item(REQ_TICK, 8'h00, 32'd3);
      send_item(REQ_SAMPLE, 8'd255, 32'd4);
      send_item(REQ_TICK, 8'h00, 32'd5);
      send_item(REQ_TICK, 8'h00, 32'd10005);
      send_item(REQ_TICK, 8'h00, 32'd10006);
      send_item(REQ_SAMPLE, 8'h55, 32'hFFFF_FFF0);
      send_item(REQ_TICK, 8'hFF, 32'h0000_0005);
      send_item(REQ_SAMPLE, 8'd90, 32'd400000);
      send_item(REQ_TICK, 8'h00, 32'd400001);
      send_item(REQ_SAMPLE, 8'd255, 32'hFFFF_FFFF);
      send_item(REQ_TICK, 8'h00, 32'hFFFF_FFFF);
      settle();

      // Zero change step with crossed limits; spare register indexes must be ignored.
      s = '{22'd3600000, 22'd3600000, 22'd3600000, 8'd100, 8'd200, 8'd0};
      apply_setting(s, 1'b0, 1'b1);
      send_item(REQ_SAMPLE, 8'd150, 32'd1000);
      send_item(REQ_TICK, 8'h00, 32'd1001);
      send_item(REQ_TICK, 8'h00, 32'd1002);
      send_item(REQ_SAMPLE, 8'd150, 32'd1003);
      send_item(REQ_TICK, 8'h00, 32'd1004);
      settle();

      // Random phases.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         apply_setting(phase_setting(p), p >= STEADY_PHASE, p == 5);
         clock_ms = $urandom_range(0, 1) ? $urandom
                  : 32'hFFFF_FFFF - $urandom_range(0, 100000);
         steady = (p == STEADY_PHASE);
         while (items_sent < 21 + (p + 1) * ITEMS_PER_PHASE) run_session();
         steady = 1'b0;
         settle();
      end

      $display("Sent %0d items (%0d evaluate ticks) over %0d register settings.",
               items_sent, ticks_sent, PHASE_COUNT + 2);
      $display("Checked %0d reports; %0d stale clears; %0d mismatches.",
               tracker.reports_seen, tracker.stale_clears, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
